/* hdl/cpba_pkg.sv */
`default_nettype none
package cpba_pkg;
  localparam int unsigned AccW = 64;
  localparam int unsigned OutW = 34;
  localparam int unsigned InW = 16;
  localparam int unsigned SampleBits = 16;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC = 2'd1;
  localparam logic [1:0] ST_DIV = 2'd2;
  localparam logic [1:0] ST_OUT = 2'd3;
  localparam logic CFG_STATION_COUNT = 1'b0;
  localparam logic CFG_SCALAR_MODE = 1'b1;
endpackage
`default_nettype wire

/* hdl/cross_power_baseline_average.sv */
// A station transaction is accepted, then takes 8 steps through one shared
// complex conjugate multiply-accumulate, one term per cycle. The last station of a source
// adds 8 restoring divisions (load, 64 quotient bits, store) before its result is valid.
// A new station is taken only once the previous one is through; input stays off until
// the pending result is taken.
// Reset: rst_n synchronous active low; clears the accumulators, station counter,
// config registers (station_count=2, scalar_mode=0) and the output valid.
`default_nettype none
module cross_power_baseline_average #(
  parameter int MAX_STATIONS = 256
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic signed [15:0] in_j00_re, in_j00_im, in_j01_re, in_j01_im,
  input  wire logic signed [15:0] in_j10_re, in_j10_im, in_j11_re, in_j11_im,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [33:0] out_v00_re, out_v00_im, out_v01_re, out_v01_im,
  output logic signed [33:0] out_v10_re, out_v10_im, out_v11_re, out_v11_im,
  input  wire logic cfg_psel,
  input  wire logic cfg_penable,
  input  wire logic cfg_pwrite,
  input  wire logic [2:0] cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  import cpba_pkg::*;

  // Prefix sums hold at most MAX_STATIONS samples, so this width never wraps.
  localparam int PsW = $clog2(MAX_STATIONS) + InW;

  logic [1:0] state_r;
  logic [8:0] count_r;
  logic scalar_r;
  logic [11:0] seen_r;
  logic signed [PsW-1:0] s_r [8];
  logic [63:0] acc_r [8];
  logic signed [15:0] q_r [8];
  logic [2:0] step_r;
  logic [6:0] bit_r;
  logic [63:0] mag_r, rem_r;
  logic neg_r;
  logic [33:0] res_r [8];
  logic [12:0] n_eff;
  logic [23:0] pairs;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == CFG_SCALAR_MODE) ? {31'd0, scalar_r} : {23'd0, count_r};
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign {out_v00_re, out_v00_im, out_v01_re, out_v01_im} = {res_r[0], res_r[1], res_r[2], res_r[3]};
  assign {out_v10_re, out_v10_im, out_v11_re, out_v11_im} = {res_r[4], res_r[5], res_r[6], res_r[7]};

  // Clamp N and form the pair count.
  always_comb begin
    n_eff = {4'd0, count_r};
    if (n_eff < 13'd2) n_eff = 13'd2;
    if (n_eff > 13'(MAX_STATIONS)) n_eff = 13'(MAX_STATIONS);
  end
  logic [25:0] nn;
  assign nn = 26'(n_eff) * 26'(n_eff - 13'd1);
  assign pairs = nn[24:1];

  function automatic logic signed [15:0] sx(input logic [15:0] v);
    logic [15:0] m;
    begin
      m = v & 16'((32'd1 << SampleBits) - 1);
      sx = signed'(16'(m << (16 - SampleBits))) >>> (16 - SampleBits);
    end
  endfunction

  // Term select: step k -> acc element a, prefix element p, q element.
  logic [1:0] ae, pe, qe;
  always_comb begin
    ae = {step_r[2], step_r[1]};
    pe = {step_r[2], step_r[0]};
    qe = {step_r[1], step_r[0]};
  end
  logic signed [PsW-1:0] pre, pim;
  logic signed [15:0] qre, qim;
  logic signed [PsW+15:0] m_rr, m_ii, m_ir, m_ri;
  logic signed [PsW+16:0] tre, tim;
  assign pre = s_r[{pe, 1'b0}];
  assign pim = s_r[{pe, 1'b1}];
  assign qre = q_r[{qe, 1'b0}];
  assign qim = q_r[{qe, 1'b1}];
  assign m_rr = (PsW+16)'(pre) * (PsW+16)'(qre);
  assign m_ii = (PsW+16)'(pim) * (PsW+16)'(qim);
  assign m_ri = (PsW+16)'(pim) * (PsW+16)'(qre);
  assign m_ir = (PsW+16)'(pre) * (PsW+16)'(qim);
  assign tre = (PsW+17)'(m_rr) + (PsW+17)'(m_ii);
  assign tim = (PsW+17)'(m_ri) - (PsW+17)'(m_ir);

  logic [64:0] trial;
  assign trial = {rem_r, mag_r[63]} - {41'd0, pairs};
  logic [63:0] acc_sel;
  assign acc_sel = acc_r[step_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= 9'd2;
      scalar_r <= 1'b0;
      seen_r <= '0;
      step_r <= '0;
      for (int i = 0; i < 8; i++) begin
        s_r[i] <= '0;
        acc_r[i] <= '0;
      end
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == CFG_STATION_COUNT) count_r <= cfg_pwdata[8:0];
        else scalar_r <= cfg_pwdata[0];
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            q_r[0] <= sx(in_j00_re); q_r[1] <= sx(in_j00_im);
            q_r[2] <= scalar_r ? 16'sd0 : sx(in_j01_re);
            q_r[3] <= scalar_r ? 16'sd0 : sx(in_j01_im);
            q_r[4] <= scalar_r ? 16'sd0 : sx(in_j10_re);
            q_r[5] <= scalar_r ? 16'sd0 : sx(in_j10_im);
            q_r[6] <= scalar_r ? 16'sd0 : sx(in_j11_re);
            q_r[7] <= scalar_r ? 16'sd0 : sx(in_j11_im);
            step_r <= '0;
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          // One complex conjugate multiply-accumulate per cycle; step wraps to zero.
          acc_r[{ae, 1'b0}] <= acc_r[{ae, 1'b0}] + 64'(tre);
          acc_r[{ae, 1'b1}] <= acc_r[{ae, 1'b1}] + 64'(tim);
          step_r <= step_r + 3'd1;
          if (step_r == 3'd7) begin
            for (int i = 0; i < 8; i++) s_r[i] <= s_r[i] + PsW'(q_r[i]);
            seen_r <= seen_r + 12'd1;
            if (13'(seen_r + 12'd1) >= n_eff) begin
              bit_r <= '0;
              state_r <= ST_DIV;
            end else state_r <= ST_IDLE;
          end
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (bit_r == 7'd0) begin
            neg_r <= acc_sel[63];
            mag_r <= acc_sel[63] ? 64'd0 - acc_sel : acc_sel;
            rem_r <= '0;
            bit_r <= 7'd1;
          end else if (bit_r <= 7'd64) begin
            if (!trial[64]) rem_r <= trial[63:0];
            else rem_r <= {rem_r[62:0], mag_r[63]};
            mag_r <= {mag_r[62:0], !trial[64]};
            bit_r <= bit_r + 7'd1;
          end else begin
            res_r[step_r] <= (scalar_r && step_r >= 3'd2) ? 34'd0 :
                             (neg_r ? 34'd0 - mag_r[33:0] : mag_r[33:0]);
            bit_r <= '0;
            step_r <= step_r + 3'd1;
            if (step_r == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                s_r[i] <= '0;
                acc_r[i] <= '0;
              end
              seen_r <= '0;
              state_r <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seen_r == 12'd0) else $error("state not cleared");
endmodule
`default_nettype wire

/* tb/cross_power_baseline_average_tb.sv */
`default_nettype none
module cross_power_baseline_average_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpba_pkg::*;

  localparam int MAX_ST = 256;
  localparam int WATCHDOG_LIMIT = 20000;
  // Worst source end is 8 divisions plus the MAC tail; round up.
  localparam int SETTLE_CYCLES = 700;
  localparam int HOLD_OFF_CYCLES = 3000;

  typedef struct {
    logic signed [15:0] j[8];
  } jones_t;

  typedef struct {
    logic [33:0] v[8];
  } cross_power_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  jones_t station = '{j: '{default: '0}};
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [33:0] out_v[8];

  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  always #6 clk = ~clk;

  cross_power_baseline_average dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_j00_re(station.j[0]), .in_j00_im(station.j[1]),
    .in_j01_re(station.j[2]), .in_j01_im(station.j[3]),
    .in_j10_re(station.j[4]), .in_j10_im(station.j[5]),
    .in_j11_re(station.j[6]), .in_j11_im(station.j[7]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_v00_re(out_v[0]), .out_v00_im(out_v[1]),
    .out_v01_re(out_v[2]), .out_v01_im(out_v[3]),
    .out_v10_re(out_v[4]), .out_v10_im(out_v[5]),
    .out_v11_re(out_v[6]), .out_v11_im(out_v[7]),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Stimulus and scoreboard storage.
  jones_t pending_stations[$];
  cross_power_t cross_power_due[$];

  // Shadow copy of the block: configuration and per-source accumulation.
  int unsigned shadow_station_count = 2;
  bit shadow_scalar = 1'b0;
  longint prefix_sum[8];
  longint pair_acc[8];
  int unsigned stations_taken = 0;

  int errors = 0;
  int stations_sent = 0;
  bit calm = 1'b0;        // no idling on either side while set
  bit hold_request = 1'b0;
  int hold_count = 0;
  int quiet_cycles = 0;

  string field_name[8] = '{"v00_re", "v00_im", "v01_re", "v01_im",
                           "v10_re", "v10_im", "v11_re", "v11_im"};

  // Signed average, truncated toward zero, kept to the low 34 bits.
  function automatic logic [33:0] baseline_mean(longint acc, longint pairs);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = (acc < 0) ? -acc : acc;
    quo = mag / pairs;
    if (acc < 0)
      quo = -quo;
    return quo[33:0];
  endfunction

  // Fold one station into the running sums; push a result on the last one.
  task automatic accumulate_station(jones_t s);
    longint q[8];
    int unsigned n;
    int pa[8];
    int qi[8];
    longint pairs;
    cross_power_t r;
    // Term table: acc[2*k/2..] += prefix[pa] * conj(q[qi]), two terms per element.
    pa = '{0, 2, 0, 2, 4, 6, 4, 6};
    qi = '{0, 2, 4, 6, 0, 2, 4, 6};
    n = shadow_station_count;
    if (n < 2)
      n = 2;
    if (n > MAX_ST)
      n = MAX_ST;
    for (int i = 0; i < 8; i++)
      q[i] = (shadow_scalar && i >= 2) ? 0 : longint'(s.j[i]);
    for (int t = 0; t < 8; t++) begin
      int e;
      e = (t / 2) * 2;
      pair_acc[e] += prefix_sum[pa[t]] * q[qi[t]] + prefix_sum[pa[t] + 1] * q[qi[t] + 1];
      pair_acc[e + 1] += prefix_sum[pa[t] + 1] * q[qi[t]] - prefix_sum[pa[t]] * q[qi[t] + 1];
    end
    for (int i = 0; i < 8; i++)
      prefix_sum[i] += q[i];
    stations_taken++;
    if (stations_taken < n)
      return;
    pairs = longint'(n) * longint'(n - 1) / 2;
    for (int i = 0; i < 8; i++) begin
      r.v[i] = (shadow_scalar && i >= 2) ? '0 : baseline_mean(pair_acc[i], pairs);
      prefix_sum[i] = 0;
      pair_acc[i] = 0;
    end
    stations_taken = 0;
    cross_power_due.push_back(r);
  endtask

  function automatic logic signed [15:0] rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 4)
      return 16'sh7fff;
    if (pick < 8)
      return 16'sh8000;
    if (pick < 10)
      return 16'sh0000;
    return 16'($urandom);
  endfunction

  function automatic jones_t rand_station();
    jones_t s;
    for (int i = 0; i < 8; i++)
      s.j[i] = rand_sample();
    return s;
  endfunction

  function automatic jones_t const_station(logic signed [15:0] a, logic signed [15:0] b);
    jones_t s;
    for (int i = 0; i < 8; i++)
      s.j[i] = i[0] ? b : a;
    return s;
  endfunction

  // Driver: advance to the next pending station once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_stations.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
        station <= pending_stations.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_request && hold_count == 0) begin
      hold_count <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_count > 1) begin
      hold_count <= hold_count - 1;
      out_ready <= 1'b0;
    end else begin
      if (hold_count == 1 && !hold_request)
        hold_count <= 0;
      out_ready <= calm || $urandom_range(0, 99) >= 29;
    end
  end

  // Monitor: predict on every input transaction, check every output transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        accumulate_station(station);
        stations_sent++;
      end
      if (out_valid && out_ready) begin
        if (cross_power_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected output transaction at %0t", $realtime);
        end else begin
          cross_power_t want;
          want = cross_power_due.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (out_v[i] !== want.v[i]) begin
              errors++;
              if (errors <= 10)
                $display("%s mismatch: expected %0d, got %0d", field_name[i],
                         $signed(want.v[i]), out_v[i]);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic cfg_write(logic idx, int unsigned value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == CFG_STATION_COUNT)
      shadow_station_count = value & 32'h1ff;
    else
      shadow_scalar = value[0];
  endtask

  // Drain everything queued, then let a trailing division finish.
  task automatic settle();
    while (!(pending_stations.size() == 0 && !in_valid && cross_power_due.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_sources(int sources, int unsigned n);
    for (int k = 0; k < sources * n; k++)
      pending_stations.push_back(rand_station());
  endtask

  initial begin
    int unsigned n;
    int phase;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full-scale pairs at the reset setting.
    pending_stations.push_back(const_station(16'sh7fff, 16'sh7fff));
    pending_stations.push_back(const_station(16'sh7fff, 16'sh7fff));
    pending_stations.push_back(const_station(16'sh8000, 16'sh8000));
    pending_stations.push_back(const_station(16'sh8000, 16'sh8000));
    pending_stations.push_back(const_station(16'sh7fff, 16'sh8000));
    pending_stations.push_back(const_station(16'sh8000, 16'sh7fff));
    settle();

    // Scalar mode: upper elements must be ignored even when loaded.
    cfg_write(CFG_SCALAR_MODE, 1);
    pending_stations.push_back(const_station(16'sh8000, 16'sh7fff));
    pending_stations.push_back(const_station(16'sh7fff, 16'sh8000));
    queue_sources(1, 2);
    settle();
    cfg_write(CFG_SCALAR_MODE, 0);

    // Station counts below the minimum clamp to two.
    cfg_write(CFG_STATION_COUNT, 0);
    queue_sources(1, 2);
    settle();
    cfg_write(CFG_STATION_COUNT, 1);
    queue_sources(1, 2);
    settle();

    // Count lowered mid-source: next station closes it with the new divisor.
    cfg_write(CFG_STATION_COUNT, 5);
    queue_sources(1, 3);
    settle();
    cfg_write(CFG_STATION_COUNT, 2);
    queue_sources(1, 1);
    settle();

    // Oversized count clamps to the maximum; drive full-scale values throughout.
    cfg_write(CFG_STATION_COUNT, 511);
    for (int k = 0; k < MAX_ST; k++)
      pending_stations.push_back(const_station(16'sh8000, 16'sh8000));
    settle();

    // Random phases, one with no idling and one with a long output hold-off.
    phase = 0;
    while (stations_sent < 1500) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)
        n = $urandom_range(2, 8);
      else if (pick < 95)
        n = $urandom_range(9, 40);
      else
        n = 256;
      cfg_write(CFG_STATION_COUNT, n);
      cfg_write(CFG_SCALAR_MODE, ($urandom_range(0, 3) == 0) ? 1 : 0);
      calm = (phase == 3);
      hold_request = (phase == 5);
      if (hold_request) begin
        cfg_write(CFG_STATION_COUNT, 2);
        queue_sources(40, 2);
      end else if (calm) begin
        // Keep the no-idle stretch long whatever the station count.
        queue_sources(200 / n + 1, n);
      end else begin
        queue_sources((n > 40) ? 1 : $urandom_range(1, 6), n);
      end
      // Occasionally leave a source unfinished; the next phase carries it on.
      if ($urandom_range(0, 9) == 0)
        pending_stations.push_back(rand_station());
      settle();
      hold_request = 1'b0;
      calm = 1'b0;
      phase++;
    end

    if (errors == 0 && cross_power_due.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
